// File: sv/rhsv_pkg.sv
// Shared types, constants and the divider step function of the RGB to HSV converter.
`default_nettype none

package rhsv_pkg;

    // Hue steps per sextant of the 256-step wheel.
    localparam logic [7:0] HUE_STEP = 8'd43;
    localparam logic [7:0] HUE_BASE_GREEN = 8'(2 * 43);
    localparam logic [7:0] HUE_BASE_BLUE = 8'(4 * 43);

    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = 8 / DIV_STEPS_PER_STAGE;
    // Front stage, numerator stage, divider stages, output register.
    localparam int PIPE_DEPTH = DIV_STAGES + 3;

    typedef enum logic [1:0] {
        SEXT_RED,
        SEXT_GREEN,
        SEXT_BLUE
    } t_sext;

    typedef struct packed {
        logic [7:0]       value;
        logic [7:0]       delta;
        t_sext            sext;
        logic signed [8:0] diff;
        logic             neg;
    } t_front;

    // Restoring divider lane: partial remainder, numerator bits / quotient, divisor.
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] acc;
        logic [7:0] dvs;
    } t_div;

    typedef struct packed {
        t_div       hue;
        t_div       sat;
        logic       hue_neg;
        logic       hue_zero;
        logic       sat_zero;
        logic [7:0] value;
    } t_pix;

    function automatic t_div div_step(input t_div x);
        logic [8:0] t;
        t_div       y;
        t = {x.rem, x.acc[7]};
        y = x;
        if (t >= {1'b0, x.dvs}) begin
            y.rem = 8'(t - {1'b0, x.dvs});
            y.acc = {x.acc[6:0], 1'b1};
        end else begin
            y.rem = t[7:0];
            y.acc = {x.acc[6:0], 1'b0};
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// File: sv/rgb_to_hsv_8bit.sv
// Top level of the pipelined 8-bit RGB to HSV pixel converter.
//
// Usage: the input channel transfers one pixel (i_red, i_green, i_blue) at
// each rising edge where i_valid is high and o_stall is low. The output
// channel transfers one result (o_hue, o_saturation, o_brightness) at each
// edge where o_valid is high and i_stall is low. Every pixel gives exactly
// one result, in order.
// On the way from an input transfer to o_valid, one stage picks
// the largest and smallest channels, one forms the hue and saturation
// numerators, four stages run the two 8-bit restoring dividers at two
// quotient bits per stage, and one register holds the result.
// One pixel per cycle while i_stall is low; the divider stages set the depth.
// Each stage holds its contents only while it is full and the stage after it
// holds, so a stall at the output fills empty stages first and reaches
// o_stall only when the whole pipeline is full. Nothing is lost or repeated.
// A synchronous reset (i_rst_n low) empties every stage; o_valid drops in
// the next cycle. Results in flight at reset are discarded.
`default_nettype none

module rgb_to_hsv_8bit (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire  [7:0] i_red,
    input  wire  [7:0] i_green,
    input  wire  [7:0] i_blue,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_hue,
    output logic [7:0] o_saturation,
    output logic [7:0] o_brightness
);

    localparam int LAST = rhsv_pkg::PIPE_DEPTH - 1;

    // Stage valid bits and load enables, index 0 is the front stage.
    logic [LAST:0]  stage_valid;
    logic [LAST:0]  stage_en;
    rhsv_pkg::t_pix div_data [0:rhsv_pkg::DIV_STAGES];

    logic       r_valid;
    logic [7:0] r_hue;
    logic [7:0] r_sat;
    logic [7:0] r_value;
    logic [7:0] n_hue;
    logic [7:0] n_sat;

    // A stage loads when it is empty or its successor loads too.
    genvar k;
    generate
        for (k = 0; k < LAST; k++) begin : g_en
            assign stage_en[k] = !stage_valid[k] || stage_en[k + 1];
        end
    endgenerate
    assign stage_en[LAST] = !stage_valid[LAST] || !i_stall;

    assign o_stall = !stage_en[0];

    rhsv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en_a    (stage_en[0]),
        .i_en_b    (stage_en[1]),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_valid_a (stage_valid[0]),
        .o_valid_b (stage_valid[1]),
        .o_data    (div_data[0])
    );

    generate
        for (k = 0; k < rhsv_pkg::DIV_STAGES; k++) begin : g_div
            rhsv_div_stage u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (stage_en[k + 2]),
                .i_valid (stage_valid[k + 1]),
                .i_data  (div_data[k]),
                .o_valid (stage_valid[k + 2]),
                .o_data  (div_data[k + 1])
            );
        end
    endgenerate

    // After the last divider stage the accumulators hold the quotients.
    // A grey pixel forces hue to zero, a black one forces saturation to zero,
    // and a negative red-sextant quotient is negated to wrap around the wheel.
    always_comb begin
        if (div_data[rhsv_pkg::DIV_STAGES].hue_zero) begin
            n_hue = 8'd0;
        end else if (div_data[rhsv_pkg::DIV_STAGES].hue_neg) begin
            n_hue = 8'd0 - div_data[rhsv_pkg::DIV_STAGES].hue.acc;
        end else begin
            n_hue = div_data[rhsv_pkg::DIV_STAGES].hue.acc;
        end
        if (div_data[rhsv_pkg::DIV_STAGES].sat_zero) begin
            n_sat = 8'd0;
        end else begin
            n_sat = div_data[rhsv_pkg::DIV_STAGES].sat.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_en[LAST]) begin
            r_valid <= stage_valid[LAST - 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[LAST]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_value <= div_data[rhsv_pkg::DIV_STAGES].value;
        end
    end

    assign stage_valid[LAST] = r_valid;
    assign o_valid = r_valid;
    assign o_hue = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_value;

endmodule

`default_nettype wire

// File: sv/rhsv_front.sv
// Front end: max/min selection, then hue and saturation numerators, two register stages.
`default_nettype none

module rhsv_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en_a,
    input  wire              i_en_b,
    input  wire              i_valid,
    input  wire  [7:0]       i_red,
    input  wire  [7:0]       i_green,
    input  wire  [7:0]       i_blue,
    output logic             o_valid_a,
    output logic             o_valid_b,
    output rhsv_pkg::t_pix   o_data
);

    logic             r_valid_a;
    logic             r_valid_b;
    rhsv_pkg::t_front r_front;
    rhsv_pkg::t_front n_front;
    rhsv_pkg::t_pix   r_pix;
    rhsv_pkg::t_pix   n_pix;

    logic [7:0]        mx;
    logic [7:0]        mn;
    logic signed [8:0] raw_diff;
    logic [7:0]        base;
    logic signed [17:0] hue_num;
    logic [15:0]       sat_num;

    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        mx = (mx > i_blue) ? mx : i_blue;
        mn = (i_red < i_green) ? i_red : i_green;
        mn = (mn < i_blue) ? mn : i_blue;
        n_front.value = mx;
        n_front.delta = mx - mn;
        n_front.neg = 1'b0;
        if (mx == i_red) begin
            n_front.sext = rhsv_pkg::SEXT_RED;
            raw_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
            // The red sextant truncates toward zero: divide the magnitude.
            n_front.neg = raw_diff[8];
            n_front.diff = raw_diff[8] ? -raw_diff : raw_diff;
        end else if (mx == i_green) begin
            n_front.sext = rhsv_pkg::SEXT_GREEN;
            raw_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
            n_front.diff = raw_diff;
        end else begin
            n_front.sext = rhsv_pkg::SEXT_BLUE;
            raw_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
            n_front.diff = raw_diff;
        end
    end

    always_comb begin
        case (r_front.sext)
            rhsv_pkg::SEXT_GREEN: base = rhsv_pkg::HUE_BASE_GREEN;
            rhsv_pkg::SEXT_BLUE:  base = rhsv_pkg::HUE_BASE_BLUE;
            default:              base = 8'd0;
        endcase
        // The numerator is never negative and stays below 2^16.
        hue_num = $signed({2'b00, 16'(base * r_front.delta)})
                + $signed({{9{r_front.diff[8]}}, r_front.diff})
                * $signed({10'd0, rhsv_pkg::HUE_STEP});
        sat_num = {r_front.delta, 8'd0} - {8'd0, r_front.delta};
        n_pix.hue.rem = hue_num[15:8];
        n_pix.hue.acc = hue_num[7:0];
        n_pix.hue.dvs = r_front.delta;
        n_pix.sat.rem = sat_num[15:8];
        n_pix.sat.acc = sat_num[7:0];
        n_pix.sat.dvs = r_front.value;
        n_pix.hue_neg = r_front.neg;
        n_pix.hue_zero = (r_front.delta == 8'd0);
        n_pix.sat_zero = (r_front.value == 8'd0);
        n_pix.value = r_front.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_en_a) begin
                r_valid_a <= i_valid;
            end
            if (i_en_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_front <= n_front;
        end
        if (i_en_b) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid_a = r_valid_a;
    assign o_valid_b = r_valid_b;
    assign o_data = r_pix;

endmodule

`default_nettype wire

// File: sv/rhsv_div_stage.sv
// One divider stage: two restoring steps on the hue and saturation lanes.
`default_nettype none

module rhsv_div_stage (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire             i_valid,
    input  rhsv_pkg::t_pix  i_data,
    output logic            o_valid,
    output rhsv_pkg::t_pix  o_data
);

    logic           r_valid;
    rhsv_pkg::t_pix r_data;
    rhsv_pkg::t_pix n_data;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < rhsv_pkg::DIV_STEPS_PER_STAGE; k++) begin
            n_data.hue = rhsv_pkg::div_step(n_data.hue);
            n_data.sat = rhsv_pkg::div_step(n_data.sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data = r_data;

endmodule

`default_nettype wire

// File: test/hsv_result_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the HSV result of every accepted pixel and compares results in order.
module hsv_result_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire  [7:0] i_red,
    input  wire  [7:0] i_green,
    input  wire  [7:0] i_blue,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire  [7:0] i_hue,
    input  wire  [7:0] i_saturation,
    input  wire  [7:0] i_brightness,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv_expect;

    t_hsv_expect hsv_expected[$];
    int          fail_count = 0;
    int          pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending_count;

    function automatic t_hsv_expect predict_hsv(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
        t_hsv_expect     res;
        int              mx;
        int              mn;
        int              delta;
        int              num;
        rhsv_pkg::t_sext sext;
        mx = (r > g) ? int'(r) : int'(g);
        mx = (mx > int'(b)) ? mx : int'(b);
        mn = (r < g) ? int'(r) : int'(g);
        mn = (mn < int'(b)) ? mn : int'(b);
        delta = mx - mn;
        res = '0;
        res.red = r;
        res.green = g;
        res.blue = b;
        res.brightness = 8'(mx);
        // Ties for the largest channel go to red, then green.
        if (r >= g && r >= b) begin
            sext = rhsv_pkg::SEXT_RED;
        end else if (g >= b) begin
            sext = rhsv_pkg::SEXT_GREEN;
        end else begin
            sext = rhsv_pkg::SEXT_BLUE;
        end
        if (delta != 0) begin
            case (sext)
                rhsv_pkg::SEXT_RED: begin
                    // Signed division truncates toward zero; negative hues wrap mod 256.
                    res.hue = 8'((int'(rhsv_pkg::HUE_STEP) * (int'(g) - int'(b))) / delta);
                end
                rhsv_pkg::SEXT_GREEN: begin
                    num = int'(rhsv_pkg::HUE_BASE_GREEN) * delta
                        + int'(rhsv_pkg::HUE_STEP) * (int'(b) - int'(r));
                    res.hue = 8'(((num < 0) ? 0 : num) / delta);
                end
                default: begin
                    num = int'(rhsv_pkg::HUE_BASE_BLUE) * delta
                        + int'(rhsv_pkg::HUE_STEP) * (int'(r) - int'(g));
                    res.hue = 8'(((num < 0) ? 0 : num) / delta);
                end
            endcase
        end
        if (mx != 0) begin
            res.saturation = 8'((255 * delta) / mx);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_hsv_expect want;
        if (i_rst_n) begin
            // Retire the oldest expectation before queuing the new pixel.
            if (i_out_valid && !i_out_stall) begin
                if (hsv_expected.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result: hue %0d sat %0d val %0d",
                                 i_hue, i_saturation, i_brightness);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = hsv_expected.pop_front();
                    if (want.hue !== i_hue || want.saturation !== i_saturation ||
                        want.brightness !== i_brightness) begin
                        if (fail_count < 10) begin
                            $display(
                                "rgb (%0d,%0d,%0d): expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                want.red, want.green, want.blue, want.hue,
                                want.saturation, want.brightness, i_hue,
                                i_saturation, i_brightness);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                hsv_expected.push_back(predict_hsv(i_red, i_green, i_blue));
            end
            pending_count <= hsv_expected.size();
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB to HSV converter: stimulus, output back-pressure and verdict.
module tb;

    // Extra wait at the end, once no result is pending any more.
    localparam int DRAIN_CYCLES = 20;
    // Longest run of cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the single long output hold-off that fills the pipeline.
    localparam int HOLD_CYCLES = 80;
    localparam int RANDOM_PIXELS = 1330;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_red = 8'd0;
    logic [7:0] i_green = 8'd0;
    logic [7:0] i_blue = 8'd0;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_hue;
    logic [7:0] o_saturation;
    logic [7:0] o_brightness;

    int fail_count;
    int pending;

    // Idling phase: 0 = sender 11% / receiver 48%, 1 = the reverse, 2 = no idling.
    int idle_phase = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    rgb_to_hsv_8bit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    hsv_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_brightness (o_brightness),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Output back-pressure. When the no-idle phase starts, the receiver first
    // holds off for a long stretch while the sender keeps offering pixels, so
    // the pipeline fills completely and o_stall must rise. After that the
    // receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (idle_phase == 2 && !hold_done) begin
            i_stall <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else begin
            case (idle_phase)
                0: i_stall <= ($urandom_range(0, 99) < 48);
                1: i_stall <= ($urandom_range(0, 99) < 11);
                default: i_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: a run of cycles with no transfer on either channel means the
    // pipeline has hung, so the run ends as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one pixel and returns once it has been transferred. Random gaps
    // before the pixel follow the sender's idling rate of the current phase.
    // Valid is only lowered inside a gap, so back-to-back pixels keep it high.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap_pct;
        gap_pct = (idle_phase == 0) ? 11 : (idle_phase == 1) ? 48 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] lvl;
        int         kind;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels: black, white, greys, each primary, every tie for the
        // largest channel, negative red-sector hues that must wrap, and the
        // smallest possible deltas.
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd200, 8'd10, 8'd50);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd85);
        send_pixel(8'd85, 8'd170, 8'd15);

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n == RANDOM_PIXELS / 3) begin
                idle_phase <= 1;
            end else if (n == (2 * RANDOM_PIXELS) / 3) begin
                idle_phase <= 2;
            end
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            kind = $urandom_range(0, 9);
            case (kind)
                4: begin
                    // Grey pixel: zero delta.
                    g = r;
                    b = r;
                end
                5: begin
                    // Two channels tie for the largest.
                    lvl = 8'($urandom_range(1, 255));
                    r = lvl;
                    g = lvl;
                    b = 8'($urandom_range(0, lvl));
                    if ($urandom_range(0, 2) == 0) begin
                        r = b;
                        b = lvl;
                    end else if ($urandom_range(0, 1) == 0) begin
                        g = b;
                        b = lvl;
                    end
                end
                6: begin
                    // Channels close together give small deltas.
                    lvl = 8'($urandom_range(0, 252));
                    r = lvl + 8'($urandom_range(0, 3));
                    g = lvl + 8'($urandom_range(0, 3));
                    b = lvl + 8'($urandom_range(0, 3));
                end
                7: begin
                    r = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'($urandom_range(0, 1));
                    g = ($urandom_range(0, 1) == 1) ? 8'd254 : 8'($urandom_range(0, 2));
                    b = ($urandom_range(0, 1) == 1) ? 8'd128 : 8'd127;
                end
                8: begin
                    // Fully saturated: one channel at full scale, another at zero.
                    case ($urandom_range(0, 2))
                        0: begin
                            r = 8'd255;
                            b = 8'd0;
                        end
                        1: begin
                            g = 8'd255;
                            r = 8'd0;
                        end
                        default: begin
                            b = 8'd255;
                            g = 8'd0;
                        end
                    endcase
                end
                default: begin
                end
            endcase
            send_pixel(r, g, b);
        end
        i_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/rhsv_pkg.sv
sv/rhsv_front.sv
sv/rhsv_div_stage.sv
sv/rgb_to_hsv_8bit.sv
test/hsv_result_checker.sv
test/tb.sv
